FILE: src/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared constants, types and codes for the line position estimator.
// ----------------------------------------------------------------------------
package lpe_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_W     = 10;
    localparam int POS_W        = 13;
    localparam int CFG_W        = 10;
    localparam int CFG_INDEX_W  = 1;
    localparam int STEP_SCALE   = 1000;

    localparam int MAX_POS    = (SENSOR_COUNT - 1) * STEP_SCALE;
    localparam int CENTRE_POS = MAX_POS / 2;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    // plain sum, quotient and accumulator widths
    localparam int PLAIN_W = $clog2(SENSOR_COUNT * SAMPLE_MAX + 1);
    localparam int Q_W     = $clog2(MAX_POS + 1);
    // weighted <= MAX_POS * plain, so this holds it and the shifted divisor
    localparam int ACC_W   = PLAIN_W + Q_W;
    localparam int PROD_W  = SAMPLE_W + Q_W;
    localparam int CNT_W   = $clog2(SENSOR_COUNT);
    localparam int DCNT_W  = $clog2(Q_W);

    localparam logic [Q_W-1:0]   STEP_Q      = Q_W'(STEP_SCALE);
    localparam logic [POS_W-1:0] MAX_POS_P   = POS_W'(MAX_POS);
    localparam logic [POS_W-1:0] CENTRE_P    = POS_W'(CENTRE_POS);
    localparam logic [CFG_W-1:0] NOISE_RESET = CFG_W'(50);
    localparam logic [CFG_W-1:0] LINE_RESET  = CFG_W'(200);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_THRESHOLD  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             carry;  // on subtract: 1 means no borrow
    } alu_rsp_t;

endpackage

FILE: src/lpe_addsub.sv
// ----------------------------------------------------------------------------
// lpe_addsub
// Shared add/subtract unit: accumulates products, then does the trial
// subtractions of the restoring divide.
// ----------------------------------------------------------------------------
module lpe_addsub
    import lpe_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ACC_W-1:0] b_op;
    logic [ACC_W:0]   total;

    assign b_op  = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + {{ACC_W{1'b0}}, req.sub};

    assign rsp.sum   = total[ACC_W-1:0];
    assign rsp.carry = total[ACC_W];

endmodule

FILE: src/line_position_estimator_top.sv
// ----------------------------------------------------------------------------
// line_position_estimator_top
// Weighted line position over a row of reflectance sensors. One frame of
// samples is taken per beat; one result beat is given per frame. A frame with
// a line goes, from acceptance to the next ready, through the accepting beat,
// the multiply-accumulate at one sample per cycle, the check state, the
// divide at one quotient bit per cycle through the shared add/subtract unit,
// and the result state, which waits on result_ready. A frame with no line
// skips the divide. sample_ready is low from acceptance until the result
// beat is taken. A frame with no sample above line_threshold, or none above
// noise_threshold, reports 0 or the far extreme depending on which side the
// line was last seen, with line_seen low. Thresholds are written through
// cfg_we/cfg_index/cfg_data and should only change while the block is idle.
// ----------------------------------------------------------------------------
module line_position_estimator_top
    import lpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [SAMPLE_W-1:0]    sample_0,
    input  logic [SAMPLE_W-1:0]    sample_1,
    input  logic [SAMPLE_W-1:0]    sample_2,
    input  logic [SAMPLE_W-1:0]    sample_3,
    input  logic [SAMPLE_W-1:0]    sample_4,
    input  logic [SAMPLE_W-1:0]    sample_5,
    input  logic [SAMPLE_W-1:0]    sample_6,
    input  logic [SAMPLE_W-1:0]    sample_7,

    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [POS_W-1:0]       position,
    output logic                   line_seen
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    noise_thr_reg, noise_thr_next;
    logic [CFG_W-1:0]    line_thr_reg, line_thr_next;
    logic [SAMPLE_W-1:0] samp_reg [SENSOR_COUNT];
    logic [SAMPLE_W-1:0] samp_next [SENSOR_COUNT];
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [Q_W-1:0]      weight_reg, weight_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    div_reg, div_next;
    logic [PLAIN_W-1:0]  plain_reg, plain_next;
    logic [Q_W-1:0]      quot_reg, quot_next;
    logic                seen_reg, seen_next;
    logic [POS_W-1:0]    last_pos_reg, last_pos_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                line_seen_reg, line_seen_next;

    logic [SAMPLE_W-1:0] cur;
    logic [PROD_W-1:0]   prod;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    lpe_addsub u_addsub (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign cur  = samp_reg[0];
    assign prod = {{Q_W{1'b0}}, cur} * {{SAMPLE_W{1'b0}}, weight_reg};

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_DONE);
    assign position     = pos_reg;
    assign line_seen    = line_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_thr_reg <= NOISE_RESET;
            line_thr_reg  <= LINE_RESET;
            last_pos_reg  <= '0;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            noise_thr_reg <= noise_thr_next;
            line_thr_reg  <= line_thr_next;
            last_pos_reg  <= last_pos_next;
            cnt_reg       <= cnt_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        samp_reg      <= samp_next;
        weight_reg    <= weight_next;
        acc_reg       <= acc_next;
        div_reg       <= div_next;
        plain_reg     <= plain_next;
        quot_reg      <= quot_next;
        seen_reg      <= seen_next;
        pos_reg       <= pos_next;
        line_seen_reg <= line_seen_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        noise_thr_next = noise_thr_reg;
        line_thr_next  = line_thr_reg;
        samp_next      = samp_reg;
        cnt_next       = cnt_reg;
        dcnt_next      = dcnt_reg;
        weight_next    = weight_reg;
        acc_next       = acc_reg;
        div_next       = div_reg;
        plain_next     = plain_reg;
        quot_next      = quot_reg;
        seen_next      = seen_reg;
        last_pos_next  = last_pos_reg;
        pos_next       = pos_reg;
        line_seen_next = line_seen_reg;

        alu_req.a   = acc_reg;
        alu_req.b   = ACC_W'(prod);
        alu_req.sub = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_NOISE_THRESHOLD: noise_thr_next = cfg_data;
                REG_LINE_THRESHOLD:  line_thr_next  = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    samp_next[0] = sample_0;
                    samp_next[1] = sample_1;
                    samp_next[2] = sample_2;
                    samp_next[3] = sample_3;
                    samp_next[4] = sample_4;
                    samp_next[5] = sample_5;
                    samp_next[6] = sample_6;
                    samp_next[7] = sample_7;
                    cnt_next     = '0;
                    weight_next  = '0;
                    acc_next     = '0;
                    plain_next   = '0;
                    seen_next    = 1'b0;
                    state_next   = ST_ACC;
                end
            end

            ST_ACC:
            begin
                if (cur > line_thr_reg)
                begin
                    seen_next = 1'b1;
                end
                if (cur > noise_thr_reg)
                begin
                    acc_next   = alu_rsp.sum;
                    plain_next = plain_reg + PLAIN_W'(cur);
                end
                for (int i = 0; i < SENSOR_COUNT - 1; i++)
                begin
                    samp_next[i] = samp_reg[i + 1];
                end
                samp_next[SENSOR_COUNT - 1] = '0;
                weight_next = weight_reg + STEP_Q;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SENSOR_COUNT - 1))
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (seen_reg && (plain_reg != '0))
                begin
                    // divisor starts at plain << (Q_W-1), quotient is below 2**Q_W
                    div_next   = ACC_W'(plain_reg) << (Q_W - 1);
                    quot_next  = '0;
                    dcnt_next  = DCNT_W'(Q_W - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    pos_next       = (last_pos_reg < CENTRE_P) ? '0 : MAX_POS_P;
                    line_seen_next = 1'b0;
                    state_next     = ST_DONE;
                end
            end

            ST_DIV:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = div_reg;
                alu_req.sub = 1'b1;
                if (alu_rsp.carry)
                begin
                    acc_next = alu_rsp.sum;
                end
                quot_next = {quot_reg[Q_W-2:0], alu_rsp.carry};
                div_next  = div_reg >> 1;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    pos_next       = POS_W'(quot_next);
                    last_pos_next  = POS_W'(quot_next);
                    line_seen_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/lpe_checker.sv
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks on the line position estimator, bound to the top level.
// ----------------------------------------------------------------------------
module lpe_checker
    import lpe_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input logic [POS_W-1:0] position,
    input logic             line_seen
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(position)
            && $stable(line_seen))
        else $error("result beat changed while stalled");

    // a held extreme is one of the two ends
    a_held_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !line_seen |-> (position == '0) || (position == MAX_POS_P))
        else $error("held position is not an extreme");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> position <= MAX_POS_P)
        else $error("position out of range");

    // one frame at a time
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !result_valid)
        else $error("ready for a frame while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready && !result_valid)
        else $error("frame finished too early");

endmodule

bind line_position_estimator_top lpe_checker u_lpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .position     (position),
    .line_seen    (line_seen)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line position estimator. A short table of
// frames covers the sensor extremes, the centre boundary, frames with no
// line, the zero plain sum and the threshold extremes. Random frames follow:
// mostly line-shaped profiles, plus quiet, fully random and threshold-edge
// frames, over several threshold settings and idling patterns. Typed table
// rows are checked against their own result, others against a local estimator.
// ----------------------------------------------------------------------------
module tb_top;
    import lpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_N        = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_FRAMES = 219;

    typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] frame_t;
    typedef longint unsigned wide_t;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic             seen;
    } position_fix_t;

    typedef struct {
        logic [CFG_W-1:0] noise;
        logic [CFG_W-1:0] line;
        frame_t           frame;   // sample_7 is the leftmost field of the literal
        bit               typed;
        logic [POS_W-1:0] pos;
        logic             seen;
    } frame_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   sample_valid;
    logic                   sample_ready;
    logic                   result_valid;
    logic                   result_ready;
    logic [POS_W-1:0]       position;
    logic                   line_seen;

    frame_t                 cur_frame;
    bit                     cur_typed;
    logic [POS_W-1:0]       cur_typed_pos;
    logic                   cur_typed_seen;

    // estimator state and its copy of the thresholds
    logic [CFG_W-1:0]       noise_thr;
    logic [CFG_W-1:0]       line_thr;
    logic [POS_W-1:0]       last_pos;

    position_fix_t          pending_fixes [$];
    frame_row_t             dir_rows [DIR_N];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int cycle_count;
    int accepted_frames;
    int fixes_seen;
    int fixes_held;
    int settings_used;

    line_position_estimator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_0     (cur_frame[0]),
        .sample_1     (cur_frame[1]),
        .sample_2     (cur_frame[2]),
        .sample_3     (cur_frame[3]),
        .sample_4     (cur_frame[4]),
        .sample_5     (cur_frame[5]),
        .sample_6     (cur_frame[6]),
        .sample_7     (cur_frame[7]),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .position     (position),
        .line_seen    (line_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // weighted average of the samples above the noise floor; holds the
    // extreme on the side last seen when no line is found
    function automatic void estimate_position(input frame_t f,
                                              output logic [POS_W-1:0] pos,
                                              output logic seen);
        wide_t weighted;
        wide_t plain;
        bit    hit;
        weighted = 0;
        plain    = 0;
        hit      = 1'b0;
        for (int k = 0; k < SENSOR_COUNT; k++)
        begin
            if (f[k] > line_thr)
                hit = 1'b1;
            if (f[k] > noise_thr)
            begin
                weighted += wide_t'(f[k]) * wide_t'(k) * wide_t'(STEP_SCALE);
                plain    += wide_t'(f[k]);
            end
        end
        if (hit && plain != 0)
        begin
            last_pos = POS_W'(weighted / plain);
            pos      = last_pos;
            seen     = 1'b1;
        end
        else
        begin
            pos  = (last_pos < CENTRE_P) ? '0 : MAX_POS_P;
            seen = 1'b0;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        return (v > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(v);
    endfunction

    function automatic frame_t make_frame();
        frame_t f;
        int     kind;
        int     centre;
        int     width;
        int     peak;
        int     d;
        kind   = $urandom_range(99);
        centre = $urandom_range(MAX_POS);
        width  = $urandom_range(2500, 300);
        peak   = $urandom_range(SAMPLE_MAX);
        for (int k = 0; k < SENSOR_COUNT; k++)
        begin
            d = k * STEP_SCALE - centre;
            if (d < 0)
                d = -d;
            if (kind < 55)
            begin
                // bump under the line over a low background
                if (d < width)
                    f[k] = clamp_sample(peak * (width - d) / width + $urandom_range(40));
                else
                    f[k] = clamp_sample($urandom_range(80));
            end
            else if (kind < 75)
                f[k] = SAMPLE_W'($urandom_range(int'(line_thr)));
            else if (kind < 90)
                f[k] = SAMPLE_W'($urandom);
            else
            begin
                case ($urandom_range(5))
                    0: f[k] = '0;
                    1: f[k] = '1;
                    2: f[k] = noise_thr;
                    3: f[k] = noise_thr + 1'b1;
                    4: f[k] = line_thr;
                    default: f[k] = line_thr + 1'b1;
                endcase
            end
        end
        return f;
    endfunction

    task automatic drive_frame(input frame_t f, input bit typed,
                               input logic [POS_W-1:0] tpos, input logic tseen);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid   <= 1'b1;
        cur_frame      <= f;
        cur_typed      <= typed;
        cur_typed_pos  <= tpos;
        cur_typed_seen <= tseen;
        do
            @(posedge clk);
        while (!(sample_valid && sample_ready));
    endtask

    // drop valid and wait for every outstanding result beat
    task automatic settle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_fixes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_NOISE_THRESHOLD)
            noise_thr = val;
        else
            line_thr = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] noise,
                                  input logic [CFG_W-1:0] line);
        settle();
        write_threshold(REG_NOISE_THRESHOLD, noise);
        write_threshold(REG_LINE_THRESHOLD, line);
        settings_used++;
    endtask

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : beat_monitor
        position_fix_t want;
        position_fix_t fresh;
        if (rst_n)
        begin
            // result beat first, then any newly accepted frame
            if (result_valid && result_ready)
            begin
                if (pending_fixes.size() == 0)
                begin
                    $error("result beat with nothing expected: position %0d line_seen %0b",
                           position, line_seen);
                    fail_count++;
                end
                else
                begin
                    want = pending_fixes.pop_front();
                    if (position !== want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos, position);
                        fail_count++;
                    end
                    if (line_seen !== want.seen)
                    begin
                        $error("line_seen: expected %0b, got %0b", want.seen, line_seen);
                        fail_count++;
                    end
                    if (want.seen)
                        fixes_seen++;
                    else
                        fixes_held++;
                end
            end
            if (sample_valid && sample_ready)
            begin
                estimate_position(cur_frame, fresh.pos, fresh.seen);
                if (cur_typed)
                begin
                    fresh.pos  = cur_typed_pos;
                    fresh.seen = cur_typed_seen;
                end
                pending_fixes.push_back(fresh);
                accepted_frames++;
            end
        end
    end

    initial
    begin
        frame_row_t row;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] l;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_NOISE_THRESHOLD;
        cfg_data       = '0;
        sample_valid   = 1'b0;
        cur_frame      = '0;
        cur_typed      = 1'b0;
        cur_typed_pos  = '0;
        cur_typed_seen = 1'b0;
        result_ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        noise_thr      = NOISE_RESET;
        line_thr       = LINE_RESET;
        last_pos       = '0;
        fail_count     = 0;
        cycle_count    = 0;
        accepted_frames = 0;
        fixes_seen     = 0;
        fixes_held     = 0;
        settings_used  = 1;

        dir_rows[0]  = '{10'd50, 10'd200, {8{10'd0}}, 1'b1, 13'd0, 1'b0};
        dir_rows[1]  = '{10'd50, 10'd200, {8{10'd1023}}, 1'b1, 13'd3500, 1'b1};
        dir_rows[2]  = '{10'd50, 10'd200, {10'd1023, {7{10'd0}}}, 1'b1, 13'd7000, 1'b1};
        dir_rows[3]  = '{10'd50, 10'd200, {8{10'd0}}, 1'b1, 13'd7000, 1'b0};
        dir_rows[4]  = '{10'd50, 10'd200, {{7{10'd0}}, 10'd1023}, 1'b1, 13'd0, 1'b1};
        dir_rows[5]  = '{10'd50, 10'd200, {8{10'd0}}, 1'b1, 13'd0, 1'b0};
        dir_rows[6]  = '{10'd50, 10'd200, {{3{10'd0}}, 10'd500, 10'd500, {3{10'd0}}},
                         1'b1, 13'd3500, 1'b1};
        // last position exactly at centre holds the right extreme
        dir_rows[7]  = '{10'd50, 10'd200, {8{10'd0}}, 1'b1, 13'd7000, 1'b0};
        dir_rows[8]  = '{10'd50, 10'd200, {{3{10'd0}}, 10'd999, 10'd1000, {3{10'd0}}},
                         1'b1, 13'd3499, 1'b1};
        dir_rows[9]  = '{10'd50, 10'd200, {8{10'd0}}, 1'b1, 13'd0, 1'b0};
        // samples at the line threshold do not count as seen
        dir_rows[10] = '{10'd50, 10'd200, {8{10'd200}}, 1'b1, 13'd0, 1'b0};
        dir_rows[11] = '{10'd50, 10'd200, {{2{10'd0}}, 10'd201, {5{10'd0}}},
                         1'b1, 13'd5000, 1'b1};
        dir_rows[12] = '{10'd50, 10'd200, {{5{10'd50}}, 10'd201, {2{10'd50}}},
                         1'b1, 13'd2000, 1'b1};
        dir_rows[13] = '{10'd50, 10'd200, {8{10'd100}}, 1'b1, 13'd0, 1'b0};
        // line seen but nothing above the noise floor
        dir_rows[14] = '{10'd1023, 10'd0, {8{10'd1023}}, 1'b1, 13'd0, 1'b0};
        dir_rows[15] = '{10'd0, 10'd1023, {8{10'd1023}}, 1'b1, 13'd0, 1'b0};
        dir_rows[16] = '{10'd0, 10'd0, {10'd0, 10'd1, {6{10'd0}}}, 1'b1, 13'd6000, 1'b1};
        dir_rows[17] = '{10'd0, 10'd0, {8{10'd0}}, 1'b1, 13'd7000, 1'b0};
        dir_rows[18] = '{10'd1022, 10'd1022, {8{10'd1023}}, 1'b1, 13'd3500, 1'b1};
        dir_rows[19] = '{10'd1022, 10'd1022, {8{10'd0}}, 1'b1, 13'd7000, 1'b0};
        dir_rows[20] = '{10'd50, 10'd200, {4{10'h2AA, 10'h155}}, 1'b0, 13'd0, 1'b0};
        dir_rows[21] = '{10'd50, 10'd200, {4{10'h155, 10'h2AA}}, 1'b0, 13'd0, 1'b0};
        dir_rows[22] = '{10'd50, 10'd200, {10'd700, 10'd600, 10'd500, 10'd400,
                                           10'd300, 10'd200, 10'd100, 10'd0},
                         1'b0, 13'd0, 1'b0};
        dir_rows[23] = '{10'd50, 10'd200, {{6{10'd51}}, 10'd1023, 10'd51},
                         1'b0, 13'd0, 1'b0};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            row = dir_rows[i];
            if (row.noise != noise_thr || row.line != line_thr)
                set_thresholds(row.noise, row.line);
            drive_frame(row.frame, row.typed, row.pos, row.seen);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin n = NOISE_RESET; l = LINE_RESET; end
                1: begin n = '0; l = '0; end
                2: begin n = '1; l = '1; end
                3: begin n = '0; l = '1; end
                4: begin n = '1; l = '0; end
                default:
                begin
                    n = CFG_W'($urandom_range(200));
                    l = CFG_W'($urandom_range(900, int'(n)));
                end
            endcase
            set_thresholds(n, l);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int j = 0; j < PHASE_FRAMES; j++)
                drive_frame(make_frame(), 1'b0, '0, 1'b0);
        end

        settle();
        repeat (30) @(posedge clk);

        $display("Checked %0d frames (%0d from the table) over %0d threshold settings.",
                 accepted_frames, DIR_N, settings_used);
        $display("Line found in %0d results, extreme held in %0d; %0d mismatches.",
                 fixes_seen, fixes_held, fail_count);
        if (fail_count == 0 && pending_fixes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
